@@ src/bdpt_pkg.sv @@
// Shared types and constants for the button debounce press timer.
package bdpt_pkg;

    localparam int unsigned SETTLE_WIDTH = 16;
    localparam int unsigned DUR_WIDTH    = 32;
    localparam int unsigned STATE_WIDTH  = 2;

    localparam logic [SETTLE_WIDTH-1:0] DEBOUNCE_RESET = 16'd20;

    // Debounce state codes as seen on the result port
    localparam logic [STATE_WIDTH-1:0] DBS_UP      = 2'd0;
    localparam logic [STATE_WIDTH-1:0] DBS_FALLING = 2'd1;
    localparam logic [STATE_WIDTH-1:0] DBS_DOWN    = 2'd2;
    localparam logic [STATE_WIDTH-1:0] DBS_RISING  = 2'd3;

    typedef struct packed {
        logic                   pressed;
        logic                   released;
        logic [DUR_WIDTH-1:0]   press_duration;
        logic [STATE_WIDTH-1:0] debounce_state;
    } t_result;

endpackage

@@ src/bdpt_if.sv @@
// Stream interfaces for the pin sample channel and the result channel.
interface bdpt_in_if;
    logic valid;
    logic ready;
    logic pin_level;

    modport source (output valid, output pin_level, input ready);
    modport sink   (input valid, input pin_level, output ready);
endinterface

interface bdpt_out_if
    import bdpt_pkg::*;
;
    logic                   valid;
    logic                   ready;
    logic                   pressed;
    logic                   released;
    logic [DUR_WIDTH-1:0]   press_duration;
    logic [STATE_WIDTH-1:0] debounce_state;

    modport source (output valid, output pressed, output released,
                    output press_duration, output debounce_state, input ready);
    modport sink   (input valid, input pressed, input released,
                    input press_duration, input debounce_state, output ready);
endinterface

@@ src/button_debounce_press_timer.sv @@
// The pin word is registered, then its result word in the result register.
// Throughput: one word per cycle when the sink is ready; the input and result
//   registers let a new word in while the previous result waits at the output.
// The whole state update is one pass through the debounce state machine.
// Reset (i_rst_n low at a clock edge) empties both registers, returns the
//   machine to up, clears all counters and flags, and loads debounce time 20.
module button_debounce_press_timer
    import bdpt_pkg::*;
#(
    parameter int unsigned TIME_WIDTH = 32
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [SETTLE_WIDTH-1:0] i_cfg_data,
    bdpt_in_if.sink                 i_in,
    bdpt_out_if.source              o_res
);

    logic    stage_valid;
    logic    stage_level;
    logic    out_free;
    logic    step;
    t_result core_result;
    t_result held_result;

    // Advance a word from the input register into the result register
    assign step = stage_valid && out_free;

    bdpt_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in.valid),
        .i_level (i_in.pin_level),
        .o_ready (i_in.ready),
        .o_valid (stage_valid),
        .o_level (stage_level),
        .i_take  (step)
    );

    // State update: runs once per advanced word
    bdpt_core #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_step     (step),
        .i_level    (stage_level),
        .o_result   (core_result)
    );

    // Hold the result until the sink takes it
    bdpt_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (step),
        .i_result (core_result),
        .i_ready  (o_res.ready),
        .o_valid  (o_res.valid),
        .o_result (held_result),
        .o_free   (out_free)
    );

    assign o_res.pressed        = held_result.pressed;
    assign o_res.released       = held_result.released;
    assign o_res.press_duration = held_result.press_duration;
    assign o_res.debounce_state = held_result.debounce_state;

endmodule

@@ src/bdpt_in_reg.sv @@
// Input register: holds one sampled pin level until the core takes it.
module bdpt_in_reg (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    input  logic i_level,
    output logic o_ready,
    output logic o_valid,
    output logic o_level,
    input  logic i_take
);

    logic r_valid;
    logic r_level;

    // Take a new word whenever the stage is empty or drains this cycle
    assign o_ready = !r_valid || i_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_level <= i_level;
        end
    end

    assign o_valid = r_valid;
    assign o_level = r_level;

endmodule

@@ src/bdpt_core.sv @@
// Debounce state machine, tick counter and press duration logic.
module bdpt_core
    import bdpt_pkg::*;
#(
    parameter int unsigned TIME_WIDTH = 32
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [SETTLE_WIDTH-1:0] i_cfg_data,
    input  logic                    i_step,
    input  logic                    i_level,
    output t_result                 o_result
);

    typedef enum logic [STATE_WIDTH-1:0] {
        S_UP      = DBS_UP,
        S_FALLING = DBS_FALLING,
        S_DOWN    = DBS_DOWN,
        S_RISING  = DBS_RISING
    } t_state;

    t_state                  r_state, n_state;
    logic [SETTLE_WIDTH-1:0] r_debounce_time;
    logic [SETTLE_WIDTH-1:0] r_settle, n_settle;
    logic [TIME_WIDTH-1:0]   r_tick;
    logic [TIME_WIDTH-1:0]   r_press_tick, n_press_tick;
    logic [TIME_WIDTH-1:0]   r_duration, n_duration;
    logic                    r_pressed, n_pressed;
    logic                    r_released, n_released;
    logic                    settle_done;
    logic [TIME_WIDTH-1:0]   elapsed;
    logic [DUR_WIDTH-1:0]    duration_out;

    assign settle_done = (r_settle >= r_debounce_time);
    assign elapsed     = r_tick - r_press_tick;

    always_comb begin
        n_state      = r_state;
        n_settle     = r_settle;
        n_press_tick = r_press_tick;
        n_duration   = r_duration;
        n_pressed    = r_pressed;
        n_released   = r_released;
        unique case (r_state)
            S_UP: begin
                n_pressed  = 1'b0;
                n_released = 1'b0;
                if (i_level) begin
                    n_state = S_FALLING;
                end
            end
            S_FALLING: begin
                if (settle_done) begin
                    n_settle = '0;
                    if (i_level) begin
                        n_state      = S_DOWN;
                        n_press_tick = r_tick;
                        n_pressed    = 1'b1;
                    end else begin
                        n_state = S_UP;
                    end
                end else begin
                    n_settle = r_settle + 1'b1;
                end
            end
            S_DOWN: begin
                if (!i_level) begin
                    n_state = S_RISING;
                end
            end
            S_RISING: begin
                if (settle_done) begin
                    n_settle = '0;
                    if (!i_level) begin
                        n_state    = S_UP;
                        n_duration = elapsed;
                        n_released = 1'b1;
                    end else begin
                        n_state = S_DOWN;
                    end
                end else begin
                    n_settle = r_settle + 1'b1;
                end
            end
            default: begin
                n_state = S_UP;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_UP;
            r_debounce_time <= DEBOUNCE_RESET;
            r_settle        <= '0;
            r_tick          <= '0;
            r_press_tick    <= '0;
            r_duration      <= '0;
            r_pressed       <= 1'b0;
            r_released      <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_debounce_time <= i_cfg_data;
            end
            if (i_step) begin
                r_state      <= n_state;
                r_settle     <= n_settle;
                r_tick       <= r_tick + 1'b1;
                r_press_tick <= n_press_tick;
                r_duration   <= n_duration;
                r_pressed    <= n_pressed;
                r_released   <= n_released;
            end
        end
    end

    // Fit the duration to the 32-bit result field
    generate
        if (TIME_WIDTH >= DUR_WIDTH) begin : g_trunc
            assign duration_out = n_duration[DUR_WIDTH-1:0];
        end else begin : g_ext
            assign duration_out = {{(DUR_WIDTH - TIME_WIDTH){1'b0}}, n_duration};
        end
    endgenerate

    assign o_result.pressed        = n_pressed;
    assign o_result.released       = n_released;
    assign o_result.press_duration = duration_out;
    assign o_result.debounce_state = n_state;

endmodule

@@ src/bdpt_out_reg.sv @@
// Result register: holds one result word until the sink takes it.
module bdpt_out_reg
    import bdpt_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_result i_result,
    input  logic    i_ready,
    output logic    o_valid,
    output t_result o_result,
    output logic    o_free
);

    logic    r_valid;
    t_result r_result;

    // Free when empty or the held word leaves this cycle
    assign o_free = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

@@ src/bdpt_checker.sv @@
// Port-level checks for the button debounce press timer, bound to the top level.
module bdpt_checker
    import bdpt_pkg::*;
(
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_out_valid,
    input logic                   i_out_ready,
    input logic                   i_pressed,
    input logic                   i_released,
    input logic [DUR_WIDTH-1:0]   i_press_duration,
    input logic [STATE_WIDTH-1:0] i_debounce_state
);

    // Reset empties the result register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    // A release is only reported from up, with the press flag still set
    a_release_in_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_released) |-> (i_debounce_state == DBS_UP && i_pressed))
        else $error("release reported outside up or without press");

    // Flags are always cleared before a new press is qualified
    a_falling_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_debounce_state == DBS_FALLING) |-> (!i_pressed && !i_released))
        else $error("stale flags while qualifying a press");

    // Down and rising always follow a confirmed press
    a_down_pressed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && (i_debounce_state == DBS_DOWN || i_debounce_state == DBS_RISING))
        |-> i_pressed)
        else $error("down or rising without press flag");

    // A stalled result word holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
        (i_out_valid && $stable(i_pressed) && $stable(i_released)
         && $stable(i_press_duration) && $stable(i_debounce_state)))
        else $error("stalled result word changed");

endmodule

bind button_debounce_press_timer bdpt_checker u_bdpt_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_out_valid      (o_res.valid),
    .i_out_ready      (o_res.ready),
    .i_pressed        (o_res.pressed),
    .i_released       (o_res.released),
    .i_press_duration (o_res.press_duration),
    .i_debounce_state (o_res.debounce_state)
);
